// ===== hw/rtl/lcpd_pkg.sv =====
// ----------------------------------------------------------------------------
// LED command packet decoder package
// Shared types, command codes and helper functions of the packet decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package lcpd_pkg;

    localparam int unsigned FRAME_COUNT  = 6;
    localparam int unsigned PIXEL_COUNT  = 192;
    localparam int unsigned PIXEL_GROUPS = PIXEL_COUNT / 3;
    // Reciprocal for the frame modulo; exact for any 8-bit value and up to eight frames.
    localparam int unsigned FRAME_RECIP  = (65536 + FRAME_COUNT - 1) / FRAME_COUNT;

    localparam logic [7:0] RESET_MIN  = 8'hF0;
    localparam logic [7:0] CMD_FLIP   = 8'h80;
    localparam logic [7:0] CMD_DOT    = 8'hC0;
    localparam logic [7:0] CMD_ADDR   = 8'hD0;
    localparam logic [7:0] CMD_UNLOCK = 8'hE0;
    localparam logic [7:0] CMD_SELECT = 8'hE1;
    localparam logic [7:0] UNLOCK_0   = 8'hF0;
    localparam logic [7:0] UNLOCK_1   = 8'hF1;
    localparam logic [7:0] UNLOCK_2   = 8'hF2;
    localparam logic [7:0] ADDR_KEY   = 8'hF5;
    localparam logic [7:0] ADDR_MIN   = 8'hF0;
    localparam logic [7:0] BROADCAST  = 8'hFF;

    localparam logic [3:0] PIXEL_LAST = 4'd2;
    localparam logic [3:0] DOT_LAST   = 4'd11;

    typedef enum logic [1:0] {
        KIND_PIXEL = 2'd0,
        KIND_FLIP  = 2'd1,
        KIND_DOT   = 2'd2,
        KIND_ADDR  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        LINK_IDLE   = 2'd0,
        LINK_READY  = 2'd1,
        LINK_ACTIVE = 2'd2
    } t_link;

    typedef enum logic [1:0] {
        POS_CMD = 2'd0,
        POS_D0  = 2'd1,
        POS_D1  = 2'd2,
        POS_D2  = 2'd3
    } t_pos;

    // A decoded packet handed from the framer to the result sequencer.
    typedef struct packed {
        logic       load;
        t_kind      kind;
        logic [7:0] base;
        logic [7:0] v0;
        logic [7:0] v1;
        logic [7:0] v2;
        logic [2:0] fa;
        logic [2:0] fb;
    } t_burst;

    function automatic logic [2:0] frame_mod(input logic [7:0] x);
        logic [24:0] prod;
        logic [7:0]  q;
        logic [10:0] qm;
        logic [10:0] rem;
        prod = 25'(x) * 25'(FRAME_RECIP);
        q    = prod[23:16];
        qm   = 11'(q) * 11'(FRAME_COUNT);
        rem  = 11'(x) - qm;
        return rem[2:0];
    endfunction

    // Packs three 6-bit correction values into the byte at position idx.
    function automatic logic [7:0] dot_byte(input logic [3:0] idx, input logic [5:0] r,
                                            input logic [5:0] g, input logic [5:0] b);
        logic [7:0] res;
        case (idx)
            4'd0, 4'd9:  res = {g[1:0], r};
            4'd1, 4'd10: res = {b[3:0], g[5:2]};
            4'd2:        res = {r, b[5:4]};
            4'd3:        res = {b[1:0], g};
            4'd4:        res = {r[3:0], b[5:2]};
            4'd5:        res = {g, r[5:4]};
            4'd6:        res = {r[1:0], b};
            4'd7:        res = {g[3:0], r[5:2]};
            4'd8:        res = {b, g[5:4]};
            4'd11:       res = {6'd0, b[5:4]};
            default:     res = 8'd0;
        endcase
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/lcpd_if.sv =====
// ----------------------------------------------------------------------------
// LED command packet decoder channels
// Valid/ready interfaces for the byte input and the result output.
// ----------------------------------------------------------------------------
`default_nettype none

interface lcpd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       address_pin;

    modport source (output valid, output data_byte, output address_pin, input ready);
    modport sink (input valid, input data_byte, input address_pin, output ready);
endinterface

interface lcpd_result_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] index;
    logic [7:0] value;
    logic [2:0] frame_a;
    logic [2:0] frame_b;
    logic       last;

    modport source (output valid, output kind, output index, output value,
                    output frame_a, output frame_b, output last, input ready);
    modport sink (input valid, input kind, input index, input value,
                  input frame_a, input frame_b, input last, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/lcpd_framer.sv =====
// ----------------------------------------------------------------------------
// LED command packet framer
// Frames bytes into packets, tracks the link state and decodes each packet.
// ----------------------------------------------------------------------------
`default_nettype none

module lcpd_framer (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    lcpd_byte_if.sink          i_byte,
    input  wire logic          i_can_load,
    output lcpd_pkg::t_burst   o_burst
);

    lcpd_pkg::t_pos  r_pos, n_pos;
    lcpd_pkg::t_link r_link, n_link;
    logic [7:0]      r_cmd, n_cmd;
    logic [7:0]      r_d0, n_d0;
    logic [7:0]      r_d1, n_d1;
    logic [7:0]      r_addr, n_addr;
    logic            r_latch, n_latch;
    logic [2:0]      r_wfs, n_wfs;
    logic [2:0]      r_dfs, n_dfs;

    logic            hs;
    logic [7:0]      b;
    logic [7:0]      new_addr;
    logic            addr_ok;
    logic [2:0]      flip_d;
    logic [2:0]      flip_w;

    // Only the last byte of a packet can produce results, so only it waits.
    assign i_byte.ready = (r_pos != lcpd_pkg::POS_D2) || i_can_load;
    assign hs           = i_byte.valid && i_byte.ready;
    assign b            = i_byte.data_byte;
    assign new_addr     = {r_d1[3:0], b[3:0]};
    assign addr_ok      = (r_d0 == lcpd_pkg::ADDR_KEY) && (r_d1 >= lcpd_pkg::ADDR_MIN)
                          && (b >= lcpd_pkg::ADDR_MIN) && (new_addr != lcpd_pkg::BROADCAST)
                          && !(r_latch && i_byte.address_pin);
    assign flip_d       = lcpd_pkg::frame_mod(r_d1);
    assign flip_w       = lcpd_pkg::frame_mod(b);

    always_comb begin
        n_pos   = r_pos;
        n_link  = r_link;
        n_cmd   = r_cmd;
        n_d0    = r_d0;
        n_d1    = r_d1;
        n_addr  = r_addr;
        n_latch = r_latch;
        n_wfs   = r_wfs;
        n_dfs   = r_dfs;
        o_burst = '0;
        if (hs) begin
            case (r_pos)
                lcpd_pkg::POS_CMD: begin
                    if (b >= lcpd_pkg::RESET_MIN) begin
                        n_link = lcpd_pkg::LINK_IDLE;
                    end else begin
                        n_cmd = b;
                        n_pos = lcpd_pkg::POS_D0;
                    end
                end
                lcpd_pkg::POS_D0: begin
                    n_d0  = b;
                    n_pos = lcpd_pkg::POS_D1;
                end
                lcpd_pkg::POS_D1: begin
                    n_d1  = b;
                    n_pos = lcpd_pkg::POS_D2;
                end
                default: begin
                    n_pos = lcpd_pkg::POS_CMD;
                    if (r_cmd < lcpd_pkg::CMD_ADDR && r_link != lcpd_pkg::LINK_ACTIVE) begin
                        n_link = r_link;
                    end else if (r_cmd == lcpd_pkg::CMD_UNLOCK) begin
                        if (r_d0 == lcpd_pkg::UNLOCK_0 && r_d1 == lcpd_pkg::UNLOCK_1
                            && b == lcpd_pkg::UNLOCK_2) begin
                            n_link = lcpd_pkg::LINK_READY;
                        end else begin
                            n_link = lcpd_pkg::LINK_IDLE;
                        end
                    end else if (r_link == lcpd_pkg::LINK_IDLE) begin
                        n_link = r_link;
                    end else if (r_cmd < 8'(lcpd_pkg::PIXEL_GROUPS)) begin
                        o_burst.load = 1'b1;
                        o_burst.kind = lcpd_pkg::KIND_PIXEL;
                        o_burst.base = (r_cmd << 1) + r_cmd;
                        o_burst.v0   = r_d0;
                        o_burst.v1   = r_d1;
                        o_burst.v2   = b;
                        o_burst.fa   = r_wfs;
                    end else if (r_cmd == lcpd_pkg::CMD_FLIP) begin
                        n_dfs        = flip_d;
                        n_wfs        = flip_w;
                        o_burst.load = 1'b1;
                        o_burst.kind = lcpd_pkg::KIND_FLIP;
                        o_burst.fa   = flip_d;
                        o_burst.fb   = flip_w;
                    end else if (r_cmd == lcpd_pkg::CMD_DOT) begin
                        o_burst.load = 1'b1;
                        o_burst.kind = lcpd_pkg::KIND_DOT;
                        o_burst.v0   = r_d0;
                        o_burst.v1   = r_d1;
                        o_burst.v2   = b;
                    end else if (r_cmd == lcpd_pkg::CMD_ADDR) begin
                        if (addr_ok) begin
                            n_addr       = new_addr;
                            o_burst.load = 1'b1;
                            o_burst.kind = lcpd_pkg::KIND_ADDR;
                            o_burst.v0   = new_addr;
                        end
                    end else if (r_cmd == lcpd_pkg::CMD_SELECT) begin
                        n_latch = 1'b1;
                        if (r_d0 == r_addr || r_d0 == lcpd_pkg::BROADCAST) begin
                            n_link = lcpd_pkg::LINK_ACTIVE;
                        end else begin
                            n_link = lcpd_pkg::LINK_READY;
                        end
                    end else begin
                        n_link = lcpd_pkg::LINK_IDLE;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= lcpd_pkg::POS_CMD;
            r_link  <= lcpd_pkg::LINK_IDLE;
            r_cmd   <= 8'd0;
            r_d0    <= 8'd0;
            r_d1    <= 8'd0;
            r_addr  <= 8'd0;
            r_latch <= 1'b0;
            r_wfs   <= 3'd0;
            r_dfs   <= 3'd0;
        end else begin
            r_pos   <= n_pos;
            r_link  <= n_link;
            r_cmd   <= n_cmd;
            r_d0    <= n_d0;
            r_d1    <= n_d1;
            r_addr  <= n_addr;
            r_latch <= n_latch;
            r_wfs   <= n_wfs;
            r_dfs   <= n_dfs;
        end
    end

    a_load_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_burst.load |-> (hs && r_pos == lcpd_pkg::POS_D2))
        else $error("packet decoded outside the last byte of a packet");

    a_load_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_burst.load |-> i_can_load)
        else $error("packet decoded while the sequencer is still busy");

    a_frames_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_wfs) < lcpd_pkg::FRAME_COUNT) && (32'(r_dfs) < lcpd_pkg::FRAME_COUNT))
        else $error("frame selection out of range");

    a_pos_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (hs && r_pos == lcpd_pkg::POS_D0) |=> (r_pos == lcpd_pkg::POS_D1))
        else $error("byte position did not advance");

endmodule

`default_nettype wire

// ===== hw/rtl/lcpd_sequencer.sv =====
// ----------------------------------------------------------------------------
// LED command packet result sequencer
// Holds one decoded packet and emits its results one word per cycle while o_result.ready is high.
// ----------------------------------------------------------------------------
`default_nettype none

module lcpd_sequencer (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire lcpd_pkg::t_burst i_burst,
    output logic               o_can_load,
    lcpd_result_if.source      o_result
);

    logic            r_busy, n_busy;
    lcpd_pkg::t_kind r_kind, n_kind;
    logic [7:0]      r_base, n_base;
    logic [7:0]      r_v0, n_v0;
    logic [7:0]      r_v1, n_v1;
    logic [7:0]      r_v2, n_v2;
    logic [2:0]      r_fa, n_fa;
    logic [2:0]      r_fb, n_fb;
    logic [3:0]      r_cnt, n_cnt;

    logic [3:0]      last_idx;
    logic            is_last;
    logic            hs;

    always_comb begin
        case (r_kind)
            lcpd_pkg::KIND_PIXEL: last_idx = lcpd_pkg::PIXEL_LAST;
            lcpd_pkg::KIND_DOT:   last_idx = lcpd_pkg::DOT_LAST;
            default:              last_idx = 4'd0;
        endcase
    end

    assign is_last    = (r_cnt == last_idx);
    assign hs         = o_result.valid && o_result.ready;
    assign o_can_load = !r_busy || (hs && is_last);

    assign o_result.valid   = r_busy;
    assign o_result.kind    = r_kind;
    assign o_result.frame_a = r_fa;
    assign o_result.frame_b = r_fb;
    assign o_result.last    = is_last;

    always_comb begin
        case (r_kind)
            lcpd_pkg::KIND_PIXEL: begin
                o_result.index = r_base + 8'(r_cnt);
                case (r_cnt[1:0])
                    2'd0:    o_result.value = r_v0;
                    2'd1:    o_result.value = r_v1;
                    default: o_result.value = r_v2;
                endcase
            end
            lcpd_pkg::KIND_DOT: begin
                o_result.index = 8'(r_cnt);
                o_result.value = lcpd_pkg::dot_byte(r_cnt, r_v0[7:2], r_v1[7:2], r_v2[7:2]);
            end
            default: begin
                // Page flips carry a zero value; address changes carry the new address.
                o_result.index = 8'd0;
                o_result.value = r_v0;
            end
        endcase
    end

    always_comb begin
        n_busy = r_busy;
        n_kind = r_kind;
        n_base = r_base;
        n_v0   = r_v0;
        n_v1   = r_v1;
        n_v2   = r_v2;
        n_fa   = r_fa;
        n_fb   = r_fb;
        n_cnt  = r_cnt;
        if (hs) begin
            if (is_last) begin
                n_busy = 1'b0;
            end else begin
                n_cnt = r_cnt + 4'd1;
            end
        end
        if (i_burst.load) begin
            n_busy = 1'b1;
            n_cnt  = 4'd0;
            n_kind = i_burst.kind;
            n_base = i_burst.base;
            n_v0   = i_burst.v0;
            n_v1   = i_burst.v1;
            n_v2   = i_burst.v2;
            n_fa   = i_burst.fa;
            n_fb   = i_burst.fb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= 4'd0;
            r_kind <= lcpd_pkg::KIND_PIXEL;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
            r_kind <= n_kind;
        end
    end

    always_ff @(posedge i_clk) begin
        r_base <= n_base;
        r_v0   <= n_v0;
        r_v1   <= n_v1;
        r_v2   <= n_v2;
        r_fa   <= n_fa;
        r_fb   <= n_fb;
    end

    a_cnt_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_cnt <= last_idx))
        else $error("result counter ran past the end of the packet");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (hs && is_last && !i_burst.load) |=> !r_busy)
        else $error("sequencer stayed busy after the final word");

    a_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (hs && !is_last) |=> (r_busy && r_cnt == $past(r_cnt) + 4'd1))
        else $error("result counter did not step");

endmodule

`default_nettype wire

// ===== hw/rtl/led_command_packet_decoder.sv =====
// The first result of a packet is offered in the cycle after its fourth byte is taken.
// Throughput: one byte per cycle; a packet yields 0, 1, 3 or 12 results, one per cycle if ready.
// The fourth byte of a packet waits while the result sequencer still holds results of an
// earlier packet, unless the final one of them is taken in the same cycle.
// Reset (synchronous, active low) clears the framing position, link state, own address,
// address latch and frame selections, and drops any pending results.
// ----------------------------------------------------------------------------
// LED command packet decoder
// Decodes 4-byte command packets from a serial link into pixel, frame and setup words.
// ----------------------------------------------------------------------------
`default_nettype none

module led_command_packet_decoder (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    lcpd_byte_if.sink       i_byte,
    lcpd_result_if.source   o_result
);

    lcpd_pkg::t_burst burst;
    logic             can_load;

    lcpd_framer u_framer (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_byte     (i_byte),
        .i_can_load (can_load),
        .o_burst    (burst)
    );

    lcpd_sequencer u_sequencer (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_burst    (burst),
        .o_can_load (can_load),
        .o_result   (o_result)
    );

endmodule

`default_nettype wire
